@@ hw/rtl/uch_pkg.sv @@
package uch_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 256;
  localparam int COUNT_BITS_DEFAULT  = 24;

  localparam int CHANNEL_W   = 8;
  localparam int KEY_W       = 3 * CHANNEL_W;
  localparam int ENTRY_IDX_W = 8;
  localparam int ENTRY_CNT_W = 24;
  localparam int UNIQUE_W    = 9;

  typedef struct packed {
    logic valid;
    logic done;
    logic fresh;
    logic last;
  } uch_flags_t;

endpackage

@@ hw/rtl/uch_cell.sv @@
module uch_cell #(
  parameter int DEPTH      = uch_pkg::TABLE_DEPTH_DEFAULT,
  parameter int COUNT_BITS = uch_pkg::COUNT_BITS_DEFAULT,
  parameter int INDEX      = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  uch_pkg::uch_flags_t            in_flags,
  input  logic [uch_pkg::KEY_W-1:0]      in_key,
  input  logic [$clog2(DEPTH)-1:0]       in_slot,
  input  logic [COUNT_BITS-1:0]          in_count,
  input  logic [$clog2(DEPTH+1)-1:0]     in_seen,
  output uch_pkg::uch_flags_t            out_flags,
  output logic [uch_pkg::KEY_W-1:0]      out_key,
  output logic [$clog2(DEPTH)-1:0]       out_slot,
  output logic [COUNT_BITS-1:0]          out_count,
  output logic [$clog2(DEPTH+1)-1:0]     out_seen
);
  import uch_pkg::*;

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int SEEN_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] SLOT = IDX_W'(INDEX);

  logic                  occ;
  logic [KEY_W-1:0]      key;
  logic [COUNT_BITS-1:0] count;
  logic                  hit;
  logic                  claim;
  logic [COUNT_BITS-1:0] count_inc;

  assign hit       = in_flags.valid && !in_flags.done && occ && (key == in_key);
  assign claim     = in_flags.valid && !in_flags.done && !occ;
  assign count_inc = (&count) ? count : count + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= 1'b0;
      out_flags <= '0;
    end else begin
      occ       <= occ | claim;
      out_flags <= in_flags;
      if (hit || claim) begin
        out_flags.done  <= 1'b1;
        out_flags.fresh <= claim;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      key   <= in_key;
      count <= COUNT_BITS'(1);
    end else if (hit) begin
      count <= count_inc;
    end
    out_key  <= in_key;
    out_slot <= (hit || claim) ? SLOT : in_slot;
    if (hit) begin
      out_count <= count_inc;
    end else if (claim) begin
      out_count <= COUNT_BITS'(1);
    end else begin
      out_count <= in_count;
    end
    out_seen <= in_seen + SEEN_W'(occ || claim);
  end

endmodule

@@ hw/rtl/unique_color_histogram_unit.sv @@
// Results: each pixel transfer yields its result strobe at the end of the cell row.
// Throughput: one pixel per cycle; busy stays low, each pixel walks the cell row
// one cell a cycle and sees every update made by the pixels ahead of it.
// Reset: clears every cell's occupancy and all in-flight pixels; stored colors
// and counts are not cleared. The receiver cannot stall: each result's done lasts one cycle.
module unique_color_histogram_unit #(
  parameter int TABLE_DEPTH = uch_pkg::TABLE_DEPTH_DEFAULT,
  parameter int COUNT_BITS  = uch_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [uch_pkg::CHANNEL_W-1:0]     red,
  input  logic [uch_pkg::CHANNEL_W-1:0]     green,
  input  logic [uch_pkg::CHANNEL_W-1:0]     blue,
  input  logic                              last_pixel,
  output logic                              done,
  output logic [uch_pkg::ENTRY_IDX_W-1:0]   entry_index,
  output logic                              was_new,
  output logic [uch_pkg::ENTRY_CNT_W-1:0]   entry_count,
  output logic [uch_pkg::UNIQUE_W-1:0]      unique_colors,
  output logic                              table_full_drop,
  output logic                              is_last
);
  import uch_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int SEEN_W = $clog2(TABLE_DEPTH + 1);

  uch_flags_t            flags [TABLE_DEPTH+1];
  logic [KEY_W-1:0]      keys  [TABLE_DEPTH+1];
  logic [IDX_W-1:0]      slots [TABLE_DEPTH+1];
  logic [COUNT_BITS-1:0] cnts  [TABLE_DEPTH+1];
  logic [SEEN_W-1:0]     seens [TABLE_DEPTH+1];

  logic [ENTRY_IDX_W+IDX_W-1:0]      slot_ext;
  logic [ENTRY_CNT_W+COUNT_BITS-1:0] count_ext;
  logic [UNIQUE_W+SEEN_W-1:0]        seen_ext;

  assign busy = 1'b0;

  always_comb begin
    flags[0].valid = start && !busy;
    flags[0].done  = 1'b0;
    flags[0].fresh = 1'b0;
    flags[0].last  = last_pixel;
  end

  assign keys[0]  = {red, green, blue};
  assign slots[0] = '0;
  assign cnts[0]  = '0;
  assign seens[0] = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    uch_cell #(
      .DEPTH      (TABLE_DEPTH),
      .COUNT_BITS (COUNT_BITS),
      .INDEX      (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_flags  (flags[g]),
      .in_key    (keys[g]),
      .in_slot   (slots[g]),
      .in_count  (cnts[g]),
      .in_seen   (seens[g]),
      .out_flags (flags[g+1]),
      .out_key   (keys[g+1]),
      .out_slot  (slots[g+1]),
      .out_count (cnts[g+1]),
      .out_seen  (seens[g+1])
    );
  end

  assign slot_ext  = {{ENTRY_IDX_W{1'b0}}, slots[TABLE_DEPTH]};
  assign count_ext = {{ENTRY_CNT_W{1'b0}}, cnts[TABLE_DEPTH]};
  assign seen_ext  = {{UNIQUE_W{1'b0}}, seens[TABLE_DEPTH]};

  assign done            = flags[TABLE_DEPTH].valid;
  assign entry_index     = slot_ext[ENTRY_IDX_W-1:0];
  assign was_new         = flags[TABLE_DEPTH].fresh;
  assign entry_count     = count_ext[ENTRY_CNT_W-1:0];
  assign unique_colors   = seen_ext[UNIQUE_W-1:0];
  assign table_full_drop = flags[TABLE_DEPTH].valid && !flags[TABLE_DEPTH].done;
  assign is_last         = flags[TABLE_DEPTH].last;

endmodule

@@ hw/rtl/uch_checker.sv @@
module uch_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic [uch_pkg::ENTRY_IDX_W-1:0]   entry_index,
  input logic                              was_new,
  input logic [uch_pkg::ENTRY_CNT_W-1:0]   entry_count,
  input logic [uch_pkg::UNIQUE_W-1:0]      unique_colors,
  input logic                              table_full_drop
);
  import uch_pkg::*;

  a_new_not_drop: assert property (@(posedge clk) disable iff (rst)
    done |-> !(was_new && table_full_drop))
    else $error("result both new and dropped");

  a_new_count_one: assert property (@(posedge clk) disable iff (rst)
    done && was_new |-> entry_count == ENTRY_CNT_W'(1) && unique_colors != '0)
    else $error("new color without count one");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    done && table_full_drop |-> entry_index == '0 && entry_count == '0)
    else $error("dropped color reports slot or count");

  a_unique_grows: assert property (@(posedge clk) disable iff (rst)
    done && $past(done) && !$past(rst) |-> unique_colors >= $past(unique_colors))
    else $error("distinct color total went down");

  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("transfer refused");

endmodule

bind unique_color_histogram_unit uch_checker u_uch_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .entry_index     (entry_index),
  .was_new         (was_new),
  .entry_count     (entry_count),
  .unique_colors   (unique_colors),
  .table_full_drop (table_full_drop)
);
